// ===== hdl/agl_pkg.sv =====
// Package for the affine-gap local alignment block.
// Holds the Q16.8 score types, the cell value struct and the saturating helpers.
// No dependencies.
package agl_pkg;

  localparam int MAX_LEN_DEF = 1024;
  localparam int SW = 24;
  localparam int CW_IN = 16;

  localparam logic [1:0] REG_GAP_OPEN   = 2'd0;
  localparam logic [1:0] REG_GAP_EXTEND = 2'd1;

  typedef logic signed [SW-1:0] score_t;
  typedef logic signed [CW_IN-1:0] coef_t;

  typedef struct packed {
    score_t match;
    score_t vgap;
    score_t hgap;
  } cell_t;

  localparam score_t Q_MAX = {1'b0, {(SW-1){1'b1}}};
  localparam score_t Q_MIN = {1'b1, {(SW-1){1'b0}}};

  function automatic score_t sat_add(input score_t a, input coef_t b);
    logic signed [SW:0] s;
    begin
      s = {a[SW-1], a} + {{(SW+1-CW_IN){b[CW_IN-1]}}, b};
      if (s[SW] != s[SW-1]) begin
        sat_add = s[SW] ? Q_MIN : Q_MAX;
      end else begin
        sat_add = s[SW-1:0];
      end
    end
  endfunction

  function automatic score_t max2(input score_t a, input score_t b);
    max2 = (a > b) ? a : b;
  endfunction

endpackage

// ===== hdl/agl_cell.sv =====
// Recurrence datapath for one alignment cell: match, vertical and horizontal gap.
// Combinational; uses agl_pkg for the score types and saturating add.
module agl_cell (
  input  agl_pkg::coef_t cell_score,
  input  agl_pkg::coef_t gap_open,
  input  agl_pkg::coef_t gap_extend,
  input  agl_pkg::cell_t up,
  input  agl_pkg::cell_t diag,
  input  agl_pkg::cell_t left,
  output agl_pkg::cell_t result
);

  agl_pkg::score_t diag_best;
  agl_pkg::score_t h_a;

  always_comb begin
    diag_best = agl_pkg::max2(agl_pkg::max2('0, diag.match),
                              agl_pkg::max2(diag.vgap, diag.hgap));
    result.match = agl_pkg::sat_add(diag_best, cell_score);
    result.vgap  = agl_pkg::max2(agl_pkg::sat_add(up.match, gap_open),
                                 agl_pkg::sat_add(up.vgap, gap_extend));
    h_a = agl_pkg::max2(agl_pkg::sat_add(left.match, gap_open),
                        agl_pkg::sat_add(left.vgap, gap_open));
    result.hgap  = agl_pkg::max2(h_a, agl_pkg::sat_add(left.hgap, gap_extend));
  end

endmodule

// ===== hdl/affine_gap_local_alignment_max.sv =====
// Affine-gap local alignment (maximum mode) over a row-streamed score matrix.
// Depends on agl_pkg and agl_cell.
//
// One cell beat is taken every cycle. A beat issues its read of the row memory
// (one entry per column, one read and one write port) on acceptance, is computed
// in stage 1 and written back as it leaves it; a one-column row is served by
// forwarding the value being written. A result beat is stored as the matrix-end
// cell leaves stage 1; the input stalls only while it waits on a full output.
module affine_gap_local_alignment_max #(
  parameter int MAX_LEN = agl_pkg::MAX_LEN_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // [15:0] cell_score
  input  logic        s_tlast,   // row_end
  input  logic        s_tuser,   // matrix_end
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,   // [23:0] best_score
  output logic        m_tuser,   // row_too_long
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  localparam int AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
  localparam int CW = $clog2(MAX_LEN + 1);

  agl_pkg::coef_t gap_open;
  agl_pkg::coef_t gap_extend;

  logic          [CW-1:0] col;
  logic                   first_row;
  logic                   accept;
  logic                   in_range;
  logic          [AW-1:0] addr;

  logic                   s1_valid;
  agl_pkg::coef_t         s1_score;
  logic                   s1_row_end;
  logic                   s1_matrix_end;
  logic                   s1_in_range;
  logic                   s1_first_row;
  logic          [AW-1:0] s1_addr;
  logic                   s1_bypass;
  agl_pkg::cell_t         s1_fwd;
  logic                   s1_fire;
  logic                   wr_en;

  agl_pkg::cell_t         mem [MAX_LEN];
  agl_pkg::cell_t         rd_data;

  agl_pkg::cell_t         left;
  agl_pkg::cell_t         diag;
  agl_pkg::cell_t         up;
  agl_pkg::cell_t         diag_use;
  agl_pkg::cell_t         cur;
  agl_pkg::score_t        best;
  agl_pkg::score_t        best_next;
  logic                   overflow;
  logic                   overflow_next;

  logic                   out_valid;
  agl_pkg::score_t        out_best;
  logic                   out_flag;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      gap_open   <= -16'sd256;
      gap_extend <= -16'sd64;
    end else if (cfg_valid) begin
      if (cfg_index == agl_pkg::REG_GAP_OPEN) begin
        gap_open <= cfg_data;
      end else if (cfg_index == agl_pkg::REG_GAP_EXTEND) begin
        gap_extend <= cfg_data;
      end
    end
  end

  assign s1_fire  = s1_valid && (!s1_matrix_end || !out_valid || m_tready);
  assign s_tready = !s1_valid || s1_fire;
  assign accept   = s_tvalid && s_tready;
  assign in_range = col < CW'(MAX_LEN);
  assign addr     = col[AW-1:0];
  assign wr_en    = s1_fire && s1_in_range;

  always_ff @(posedge clk) begin
    if (rst) begin
      col       <= '0;
      first_row <= 1'b1;
    end else if (accept) begin
      if (s_tuser) begin
        col       <= '0;
        first_row <= 1'b1;
      end else if (s_tlast) begin
        col       <= '0;
        first_row <= 1'b0;
      end else if (in_range) begin
        col <= col + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (s1_fire) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_score      <= s_tdata;
      s1_row_end    <= s_tlast;
      s1_matrix_end <= s_tuser;
      s1_in_range   <= in_range;
      s1_first_row  <= first_row;
      s1_addr       <= addr;
      s1_bypass     <= wr_en && (s1_addr == addr);
      s1_fwd        <= cur;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[s1_addr] <= cur;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rd_data <= mem[addr];
    end
  end

  always_comb begin
    if (s1_first_row || !s1_in_range) begin
      up = '0;
    end else if (s1_bypass) begin
      up = s1_fwd;
    end else begin
      up = rd_data;
    end
    diag_use      = s1_in_range ? diag : '0;
    best_next     = agl_pkg::max2(best, cur.match);
    overflow_next = overflow || !s1_in_range;
  end

  agl_cell u_cell (
    .cell_score (s1_score),
    .gap_open   (gap_open),
    .gap_extend (gap_extend),
    .up         (up),
    .diag       (diag_use),
    .left       (left),
    .result     (cur)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      left     <= '0;
      diag     <= '0;
      best     <= '0;
      overflow <= 1'b0;
    end else if (s1_fire) begin
      if (s1_matrix_end) begin
        left     <= '0;
        diag     <= '0;
        best     <= '0;
        overflow <= 1'b0;
      end else if (s1_row_end) begin
        left     <= '0;
        diag     <= '0;
        best     <= best_next;
        overflow <= overflow_next;
      end else begin
        left     <= cur;
        diag     <= s1_in_range ? up : '0;
        best     <= best_next;
        overflow <= overflow_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_fire && s1_matrix_end) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire && s1_matrix_end) begin
      out_best <= best_next;
      out_flag <= overflow_next;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = out_best;
  assign m_tuser  = out_flag;

endmodule

// ===== sim/affine_gap_local_alignment_max_tb.sv =====
// Self-checking testbench for affine_gap_local_alignment_max.
// Streams score matrices with random flow control and checks each best-score beat against
// a cell-by-cell alignment predictor. Depends on agl_pkg and the block itself.
module affine_gap_local_alignment_max_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] REG_SPARE_2 = 2'd2;
  localparam logic [1:0] REG_SPARE_3 = 2'd3;
  localparam int CYCLE_LIMIT = 200000;
  localparam int STALL_CYCLES = 400;
  localparam int PHASE_CELLS = 30;
  localparam agl_pkg::score_t ZERO = '0;

  typedef struct packed {
    agl_pkg::score_t best;
    logic            too_long;
  } align_result_t;

  typedef struct packed {
    agl_pkg::coef_t  score;
    logic            row_end;
    logic            mat_end;
    bit              typed;
    agl_pkg::score_t best;
    logic            too_long;
  } plan_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [15:0] s_tdata = '0;
  logic        s_tlast = 1'b0;
  logic        s_tuser = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [23:0] m_tdata;
  logic        m_tuser;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [15:0] cfg_data = '0;

  affine_gap_local_alignment_max dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .s_tlast(s_tlast), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  // alignment predictor state
  agl_pkg::coef_t  gap_open = -16'sd256;
  agl_pkg::coef_t  gap_ext = -16'sd64;
  agl_pkg::score_t mem_m [agl_pkg::MAX_LEN_DEF];
  agl_pkg::score_t mem_v [agl_pkg::MAX_LEN_DEF];
  agl_pkg::score_t mem_h [agl_pkg::MAX_LEN_DEF];
  int              mem_cols = 0;
  agl_pkg::score_t left_m, left_v, left_h, diag_m, diag_v, diag_h;
  int              col;
  bit              first_row;
  agl_pkg::score_t best;
  bit              too_long;

  align_result_t expected_best [$];
  int  mismatches = 0;
  int  cycles = 0;
  int  cells_sent = 0;
  bit  calm = 1'b0;
  int  stall_asked = 0;

  plan_row_t plan [19] = '{
    '{16'sh7FFF, 1'b1, 1'b1, 1'b1, 24'sd32767, 1'b0},
    '{16'sh8000, 1'b1, 1'b1, 1'b1, 24'sd0, 1'b0},
    '{16'sh0000, 1'b0, 1'b1, 1'b1, 24'sd0, 1'b0},
    '{16'sh0100, 1'b0, 1'b0, 1'b0, 24'sd0, 1'b0},
    '{16'sh0064, 1'b1, 1'b0, 1'b0, 24'sd0, 1'b0},
    '{16'sh0032, 1'b0, 1'b0, 1'b0, 24'sd0, 1'b0},
    '{16'sh012C, 1'b0, 1'b1, 1'b0, 24'sd0, 1'b0},
    '{16'shFFFF, 1'b0, 1'b0, 1'b0, 24'sd0, 1'b0},
    '{16'sh7FFF, 1'b0, 1'b0, 1'b0, 24'sd0, 1'b0},
    '{16'sh0001, 1'b1, 1'b0, 1'b0, 24'sd0, 1'b0},
    '{16'sh5555, 1'b0, 1'b0, 1'b0, 24'sd0, 1'b0},
    '{16'shAAAA, 1'b0, 1'b0, 1'b0, 24'sd0, 1'b0},
    '{16'sh7FFF, 1'b1, 1'b0, 1'b0, 24'sd0, 1'b0},
    '{16'sh8000, 1'b0, 1'b0, 1'b0, 24'sd0, 1'b0},
    '{16'sh1234, 1'b1, 1'b1, 1'b0, 24'sd0, 1'b0},
    '{16'sh0100, 1'b1, 1'b0, 1'b0, 24'sd0, 1'b0},
    '{16'sh0080, 1'b0, 1'b0, 1'b0, 24'sd0, 1'b0},
    '{16'sh0080, 1'b0, 1'b0, 1'b0, 24'sd0, 1'b0},
    '{16'sh0080, 1'b1, 1'b1, 1'b0, 24'sd0, 1'b0}
  };

  initial begin
    forever #1 clk = ~clk;
  end

  initial begin
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles >= CYCLE_LIMIT) begin
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  function automatic agl_pkg::score_t clamp_add(input agl_pkg::score_t a,
                                                input agl_pkg::coef_t b);
    int t;
    t = int'(a) + int'(b);
    if (t > int'(agl_pkg::Q_MAX)) return agl_pkg::Q_MAX;
    if (t < int'(agl_pkg::Q_MIN)) return agl_pkg::Q_MIN;
    return agl_pkg::score_t'(t);
  endfunction

  function automatic agl_pkg::score_t larger(input agl_pkg::score_t a,
                                             input agl_pkg::score_t b);
    return (a > b) ? a : b;
  endfunction

  function automatic void matrix_clear();
    left_m = '0; left_v = '0; left_h = '0;
    diag_m = '0; diag_v = '0; diag_h = '0;
    col = 0;
    first_row = 1'b1;
    best = '0;
    too_long = 1'b0;
  endfunction

  function automatic bit advance_cell(input agl_pkg::coef_t s, input logic re,
                                      input logic me, output align_result_t res);
    bit              in_range;
    agl_pkg::score_t um, uv, uh, dm, dv, dh, m, v, h;
    in_range = col < agl_pkg::MAX_LEN_DEF;
    um = '0; uv = '0; uh = '0;
    dm = '0; dv = '0; dh = '0;
    if (in_range) begin
      if (!first_row) begin
        um = mem_m[col];
        uv = mem_v[col];
        uh = mem_h[col];
      end
      dm = diag_m; dv = diag_v; dh = diag_h;
    end else begin
      too_long = 1'b1;
    end
    m = clamp_add(larger(larger(ZERO, dm), larger(dv, dh)), s);
    v = larger(clamp_add(um, gap_open), clamp_add(uv, gap_ext));
    h = larger(larger(clamp_add(left_m, gap_open), clamp_add(left_v, gap_open)),
               clamp_add(left_h, gap_ext));
    best = larger(best, m);
    if (in_range) begin
      diag_m = um; diag_v = uv; diag_h = uh;
      mem_m[col] = m; mem_v[col] = v; mem_h[col] = h;
      col++;
      if (col > mem_cols) mem_cols = col;
    end else begin
      diag_m = '0; diag_v = '0; diag_h = '0;
    end
    left_m = m; left_v = v; left_h = h;
    res = '{best, too_long};
    if (me) begin
      matrix_clear();
      return 1'b1;
    end
    if (re) begin
      left_m = '0; left_v = '0; left_h = '0;
      diag_m = '0; diag_v = '0; diag_h = '0;
      col = 0;
      first_row = 1'b0;
    end
    return 1'b0;
  endfunction

  task automatic report(input string field, input logic [23:0] want, input logic [23:0] got);
    $display("mismatch %s: expected %h got %h at cycle %0d", field, want, got, cycles);
    mismatches++;
  endtask

  task automatic check_result();
    align_result_t e;
    if (expected_best.size() == 0) begin
      report("unexpected beat", '0, m_tdata);
      return;
    end
    e = expected_best.pop_front();
    if (m_tdata !== e.best) report("best_score", e.best, m_tdata);
    if (m_tuser !== e.too_long) report("row_too_long", 24'(e.too_long), 24'(m_tuser));
  endtask

  initial begin
    int stall_served;
    int stall_left;
    stall_served = 0;
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (m_tvalid && m_tready) check_result();
      if (stall_asked != stall_served) begin
        stall_served = stall_asked;
        stall_left = STALL_CYCLES;
      end
      if (stall_left > 0) begin
        stall_left--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= calm || ($urandom_range(0, 99) >= 28);
      end
    end
  end

  task automatic put_cell(input agl_pkg::coef_t s, input logic re, input logic me,
                          input bit typed, input align_result_t fixed);
    align_result_t r;
    while (!calm && $urandom_range(0, 99) < 28) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= s;
    s_tlast <= re;
    s_tuser <= me;
    do @(posedge clk); while (!s_tready);
    cells_sent++;
    if (advance_cell(s, re, me, r)) expected_best.push_back(typed ? fixed : r);
  endtask

  task automatic put_reg(input logic [1:0] idx, input agl_pkg::coef_t value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == agl_pkg::REG_GAP_OPEN) gap_open = value;
    else if (idx == agl_pkg::REG_GAP_EXTEND) gap_ext = value;
  endtask

  task automatic set_gaps(input agl_pkg::coef_t open_val, input agl_pkg::coef_t ext_val);
    put_reg(agl_pkg::REG_GAP_OPEN, open_val);
    put_reg(agl_pkg::REG_GAP_EXTEND, ext_val);
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    while (expected_best.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  function automatic agl_pkg::coef_t rand_score();
    unique case ($urandom_range(0, 9))
      0: return 16'sh7FFF;
      1: return 16'sh8000;
      2, 3: return agl_pkg::coef_t'($urandom);
      default: return agl_pkg::coef_t'($urandom_range(0, 1023)) - 16'sd512;
    endcase
  endfunction

  function automatic agl_pkg::coef_t rand_gap();
    if ($urandom_range(0, 2) == 0) return agl_pkg::coef_t'($urandom);
    return -agl_pkg::coef_t'($urandom_range(0, 1024));
  endfunction

  task automatic send_matrix(input int shape[$], input bit end_open);
    bit last;
    for (int r = 0; r < shape.size(); r++) begin
      for (int c = 0; c < shape[r]; c++) begin
        last = (r == shape.size() - 1) && (c == shape[r] - 1);
        put_cell(rand_score(), (c == shape[r] - 1) && !(last && end_open), last, 1'b0, '0);
      end
    end
  endtask

  // later rows never reach past the columns already held in the row memory
  task automatic random_matrix();
    int shape[$];
    int rows;
    int bound;
    rows = $urandom_range(1, 5);
    shape.push_back($urandom_range(1, 8));
    bound = (mem_cols > shape[0]) ? mem_cols : shape[0];
    if (bound > 8) bound = 8;
    for (int r = 1; r < rows; r++) shape.push_back($urandom_range(1, bound));
    send_matrix(shape, $urandom_range(0, 3) == 0);
  endtask

  initial begin
    int shape[$];
    int start;
    matrix_clear();
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    foreach (plan[i])
      put_cell(plan[i].score, plan[i].row_end, plan[i].mat_end, plan[i].typed,
               '{plan[i].best, plan[i].too_long});

    for (int ph = 0; ph < 8; ph++) begin
      drain();
      unique case (ph)
        0: begin
          set_gaps(16'sh8000, 16'sh8000);
          put_reg(REG_SPARE_2, agl_pkg::coef_t'($urandom));
          put_reg(REG_SPARE_3, agl_pkg::coef_t'($urandom));
        end
        1: set_gaps(16'sh7FFF, 16'sh7FFF);
        2: begin
          set_gaps(16'sh0000, 16'sh0000);
          calm = 1'b1;
        end
        3: begin
          set_gaps(rand_gap(), rand_gap());
          calm = 1'b0;
          stall_asked++;
          shape = {1};
          repeat (24) send_matrix(shape, 1'b0);
          drain();
        end
        4: begin
          set_gaps(16'sh8000, 16'sh7FFF);
          calm = 1'b1;
          shape = {1025, 3};
          send_matrix(shape, 1'b0);
          calm = 1'b0;
        end
        5: set_gaps(16'sh8000, 16'sh8000);
        default: set_gaps(rand_gap(), rand_gap());
      endcase
      start = cells_sent;
      while (cells_sent - start < PHASE_CELLS) random_matrix();
    end

    drain();
    repeat (10) @(posedge clk);
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
